// File: hdl/tbwp_pkg.sv
`timescale 1ns / 1ps

package tbwp_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    CMD_WR_VRAM    = 2'd0,
    CMD_WR_PALETTE = 2'd1,
    CMD_RENDER     = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y    = 3'd1;
  localparam logic [2:0] REG_SCROLL_X    = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y    = 3'd3;
  localparam logic [2:0] REG_WINDOW_X    = 3'd4;
  localparam logic [2:0] REG_SHADE_MAP   = 3'd5;
  localparam logic [2:0] REG_COLOR_MODE  = 3'd6;

  localparam logic [7:0] SHADE_MAP_RESET = 8'd252;

  // Color modes; the last one acts as full color
  localparam logic [1:0] MODE_MONO     = 2'd0;
  localparam logic [1:0] MODE_COMPAT   = 2'd1;
  localparam logic [1:0] MODE_FULL     = 2'd2;
  localparam logic [1:0] MODE_FULL_ALT = 2'd3;

  // Video RAM geometry: each bank is split into even and odd byte halves
  localparam int BANK_BYTES = 8192;
  localparam int WORD_DEPTH = BANK_BYTES / 2;
  localparam int WORD_AW    = $clog2(WORD_DEPTH);

  // Palette RAM: 32 colors of two bytes each
  localparam int PAL_DEPTH = 32;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Screen limits
  localparam logic [7:0] LAST_ROW    = 8'd143;
  localparam logic [7:0] LAST_COLUMN = 8'd159;
  localparam logic [7:0] WX_OFFSET   = 8'd7;

  // Tile set 1 base within a bank
  localparam logic [12:0] SET1_BASE = 13'h0800;

  // Output queue depth
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Fixed monochrome greys, 15-bit color
  localparam logic [14:0] GREYS [4] = '{15'h7FFF, 15'h56B5, 15'h294A, 15'h0000};

  // 5-bit channel to 8-bit channel, c*255/31 truncated
  localparam logic [7:0] C5_TO_C8 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // One result item
  typedef struct packed {
    logic [23:0] rgb;
    logic        bg_priority;
    logic [1:0]  color_index;
    logic        drawn;
  } result_t;

endpackage

// File: hdl/tile_background_window_pixel_core.sv
`timescale 1ns / 1ps

// Background and window pixel renderer of a tile display.
// Input channel (s_axis): tuser holds the item kind (video RAM write, palette
// write, render); tdata holds address, data, row and column. Config writes go
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must issue them only
// while the block is idle, which the block itself does not enforce.
// Output channel (m_axis): one result item per render item, none for writes.
// The read chain is map/attribute port, tile byte port, palette port, then
// color conversion into a four-entry output queue; m_axis_tvalid rises once
// a result is written into the queue. Throughput: one render item per cycle
// while the output queue has room. A write item waits while a render item
// sits in the first two stages, so its reads see the older contents.
// Reset clears the registers, the stage valids and the queue; the video and
// palette RAMs hold whatever was last written and need no clearing.
// When the receiver stalls, the queue fills and render items are held off
// only once queued plus in-flight results reach the queue depth.
module tile_background_window_pixel_core #(
  parameter int SCREEN_WIDTH = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // address[13:0], data[7:0], row[7:0], column[7:0]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // drawn, color_index[1:0], bg_priority, rgb[23:0]
);

  import tbwp_pkg::*;

  // Config registers
  logic [7:0] lcdc_q, scy_q, scx_q, wy_q, wx_q, bgp_q;
  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= '0;
      scy_q  <= '0;
      scx_q  <= '0;
      wy_q   <= '0;
      wx_q   <= '0;
      bgp_q  <= SHADE_MAP_RESET;
      mode_q <= MODE_MONO;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LCD_CONTROL: lcdc_q <= cfg_data_i;
        REG_SCROLL_Y:    scy_q  <= cfg_data_i;
        REG_SCROLL_X:    scx_q  <= cfg_data_i;
        REG_WINDOW_Y:    wy_q   <= cfg_data_i;
        REG_WINDOW_X:    wx_q   <= cfg_data_i;
        REG_SHADE_MAP:   bgp_q  <= cfg_data_i;
        REG_COLOR_MODE:  mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic full, use_pal;
  assign full    = (mode_q >= MODE_FULL);
  assign use_pal = (mode_q != MODE_MONO);

  // Input fields
  cmd_e        in_cmd;
  logic [13:0] in_addr;
  logic [7:0]  in_data, in_row, in_col;

  assign in_cmd  = cmd_e'(s_axis_tuser);
  assign in_addr = s_axis_tdata[13:0];
  assign in_data = s_axis_tdata[21:14];
  assign in_row  = s_axis_tdata[29:22];
  assign in_col  = s_axis_tdata[37:30];

  // Stage valids and output queue state
  logic              v1_q, v2_q, v3_q;
  logic [OUT_AW:0]   count_q;
  logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
  result_t           queue_q [OUT_DEPTH];

  logic              accept, acc_render, pop;
  logic [1:0]        inflight;
  logic [OUT_AW+1:0] used, limit;
  logic              space;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign inflight = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);
  assign used     = (OUT_AW + 2)'(count_q) + (OUT_AW + 2)'(inflight);
  assign limit    = (OUT_AW + 2)'(OUT_DEPTH) + (OUT_AW + 2)'(pop);
  assign space    = (used < limit);

  // Renders need queue room; writes wait for pending reads of earlier renders
  always_comb begin
    case (in_cmd)
      CMD_RENDER:                    s_axis_tready = space;
      CMD_WR_VRAM, CMD_WR_PALETTE:   s_axis_tready = !(v1_q || v2_q);
      default:                       s_axis_tready = 1'b1;
    endcase
  end

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign acc_render = accept && (in_cmd == CMD_RENDER);

  // Stage 0: position, window test and map address
  logic [7:0]  wx_edge, win_line, win_col, bg_line, bg_col, sel_line, sel_col;
  logic        in_window, on_screen, layer_on, map_hi;
  logic [12:0] map_addr;

  always_comb begin
    wx_edge   = (wx_q < WX_OFFSET) ? 8'd0 : wx_q - WX_OFFSET;
    in_window = lcdc_q[5] && (wy_q <= in_row) && (wy_q <= LAST_ROW) &&
                (wx_edge <= LAST_COLUMN) && (in_col >= wx_edge);
    win_line  = in_row - wy_q;
    win_col   = in_col - wx_edge;
    bg_line   = in_row + scy_q;
    bg_col    = in_col + scx_q;
    sel_line  = in_window ? win_line : bg_line;
    sel_col   = in_window ? win_col : bg_col;
    map_hi    = in_window ? lcdc_q[6] : lcdc_q[3];
    map_addr  = {2'b11, map_hi, sel_line[7:3], sel_col[7:3]};
    layer_on  = lcdc_q[7] && (lcdc_q[0] || full);
    on_screen = (in_row <= LAST_ROW) && ({1'b0, in_col} < 9'(SCREEN_WIDTH));
  end

  logic [2:0] s1_line_q, s1_px_q;
  logic       s1_vflip_ok_q, s1_par_q, s1_drawn_q;

  always_ff @(posedge clk_i) begin
    if (acc_render) begin
      s1_line_q     <= sel_line[2:0];
      s1_px_q       <= sel_col[2:0];
      s1_vflip_ok_q <= !in_window;
      s1_par_q      <= map_addr[0];
      s1_drawn_q    <= layer_on && on_screen;
    end
  end

  // Video RAM: [bank][byte parity]
  logic [7:0]         vram_rd_a [2][2];
  logic [7:0]         vram_rd_b [2][2];
  logic [WORD_AW-1:0] tile_word;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    for (genvar p = 0; p < 2; p++) begin : g_par
      logic vram_we;
      assign vram_we = accept && (in_cmd == CMD_WR_VRAM) &&
                       (in_addr[13] == 1'(b)) && (in_addr[0] == 1'(p));
      tbwp_ram #(
        .WIDTH (8),
        .DEPTH (WORD_DEPTH)
      ) u_vram (
        .clk_i     (clk_i),
        .we_i      (vram_we),
        .waddr_i   (in_addr[WORD_AW:1]),
        .wdata_i   (in_data),
        .raddr_a_i (map_addr[WORD_AW:1]),
        .rdata_a_o (vram_rd_a[b][p]),
        .raddr_b_i (tile_word),
        .rdata_b_o (vram_rd_b[b][p])
      );
    end
  end

  // Stage 1: tile index and attribute -> tile row address
  logic [7:0]  tile_num, attr;
  logic [12:0] tile_base;
  logic [2:0]  tile_line, px_bit;

  always_comb begin
    tile_num  = s1_par_q ? vram_rd_a[0][1] : vram_rd_a[0][0];
    attr      = full ? (s1_par_q ? vram_rd_a[1][1] : vram_rd_a[1][0]) : 8'd0;
    tile_base = lcdc_q[4] ? {1'b0, tile_num, 4'b0000}
                          : SET1_BASE + {1'b0, tile_num ^ 8'h80, 4'b0000};
    tile_line = (s1_vflip_ok_q && attr[6]) ? 3'd7 - s1_line_q : s1_line_q;
    tile_word = {tile_base[12:4], tile_line};
    px_bit    = attr[5] ? s1_px_q : 3'd7 - s1_px_q;
  end

  logic       s2_bank_q, s2_prio_q, s2_drawn_q;
  logic [2:0] s2_bit_q, s2_pal_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_bank_q  <= attr[3];
      s2_bit_q   <= px_bit;
      s2_pal_q   <= attr[2:0];
      s2_prio_q  <= attr[7];
      s2_drawn_q <= s1_drawn_q;
    end
  end

  // Stage 2: tile bytes -> color index, shade and palette entry
  logic [7:0]        plane0, plane1;
  logic [1:0]        cid, shade;
  logic [PAL_AW-1:0] pal_entry;

  always_comb begin
    plane0    = vram_rd_b[s2_bank_q][0];
    plane1    = vram_rd_b[s2_bank_q][1];
    cid       = {plane1[s2_bit_q], plane0[s2_bit_q]};
    shade     = bgp_q[{cid, 1'b0} +: 2];
    pal_entry = full ? {s2_pal_q, cid} : {3'b000, shade};
  end

  // Palette RAM: low byte on port a, high byte on port b
  logic [7:0] pal_lo, pal_hi;
  logic       pal_we;

  assign pal_we = accept && (in_cmd == CMD_WR_PALETTE) && (in_addr[13:6] == 8'd0);

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (2 * PAL_DEPTH)
  ) u_pal (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (in_addr[PAL_AW:0]),
    .wdata_i   (in_data),
    .raddr_a_i ({pal_entry, 1'b0}),
    .rdata_a_o (pal_lo),
    .raddr_b_i ({pal_entry, 1'b1}),
    .rdata_b_o (pal_hi)
  );

  logic [1:0] s3_cid_q, s3_shade_q;
  logic       s3_prio_q, s3_drawn_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      s3_cid_q   <= cid;
      s3_shade_q <= shade;
      s3_prio_q  <= full && s2_prio_q;
      s3_drawn_q <= s2_drawn_q;
    end
  end

  // Stage 3: 15-bit color -> 24-bit RGB
  logic [14:0] color15;
  result_t     result;

  always_comb begin
    color15 = use_pal ? {pal_hi[6:0], pal_lo} : GREYS[s3_shade_q];
    result  = '0;
    if (s3_drawn_q) begin
      result.drawn       = 1'b1;
      result.color_index = s3_cid_q;
      result.bg_priority = s3_prio_q;
      result.rgb         = {C5_TO_C8[color15[4:0]], C5_TO_C8[color15[9:5]],
                            C5_TO_C8[color15[14:10]]};
    end
  end

  // Stage valids and output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      v1_q <= acc_render;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (OUT_AW + 1)'(v3_q) - (OUT_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      queue_q[wr_ptr_q] <= result;
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {4'b0000, queue_q[rd_ptr_q]};

endmodule

// File: hdl/tbwp_ram.sv
`timescale 1ns / 1ps

// Simple RAM: one write port, two registered read ports (read-first)
module tbwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: tb/tb_tile_background_window_pixel_core.sv
`timescale 1ns / 1ps

module tb_tile_background_window_pixel_core;
  import tbwp_pkg::*;

  localparam int SCREEN_W        = 160;
  localparam int VRAM_BYTES      = 2 * BANK_BYTES;
  localparam int PAL_BYTES       = 64;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 95;

  localparam logic [12:0] MAP_LOW  = 13'h1800;
  localparam logic [12:0] MAP_HIGH = 13'h1C00;

  // One directed row: register settings, then the item
  typedef struct packed {
    logic [7:0]  lcdc;
    logic [7:0]  scy;
    logic [7:0]  scx;
    logic [7:0]  wy;
    logic [7:0]  wx;
    logic [7:0]  shade;
    logic [1:0]  mode;
    cmd_e        kind;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        blank;  // render known to give an all-zero result
  } probe_t;

  // Rows before the memory fill read no memory at all
  localparam int N_BLANK_PROBES = 9;
  localparam int N_PROBES       = 26;

  probe_t probes [N_PROBES] = '{
    // reset settings, display off
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd0, 8'd0, 1'b1},
    // display on, tile layer off
    {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_RENDER, 14'h3FFF, 8'hFF, 8'd0, 8'd0, 1'b1},
    {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_COMPAT,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd159, 1'b1},
    // off screen
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd144, 8'd0, 1'b1},
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd255, 8'd255, 1'b1},
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd0, 8'd160, 1'b1},
    // unused kind and out-of-range palette writes do nothing
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_NONE, 14'h3FFF, 8'hFF, 8'd255, 8'd255, 1'b0},
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_WR_PALETTE, 14'h0040, 8'hFF, 8'd0, 8'd0, 1'b0},
    {8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, MODE_MONO,
     CMD_WR_PALETTE, 14'h3FFF, 8'hFF, 8'd0, 8'd0, 1'b0},
    // background, unsigned tile set
    {8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd0, 8'd0, 1'b0},
    // signed tile set, scroll wraps, last pixel
    {8'h81, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h1B, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd159, 1'b0},
    // high background map, compat palette lookup
    {8'h89, 8'h10, 8'h07, 8'h00, 8'h00, 8'hE4, MODE_COMPAT,
     CMD_RENDER, 14'h0000, 8'h00, 8'd77, 8'd33, 1'b0},
    // window with left position below seven
    {8'hA1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd0, 8'd0, 1'b0},
    // window on high map
    {8'hE1, 8'h00, 8'h00, 8'h0A, 8'h07, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd159, 1'b0},
    // window top below the screen disables it
    {8'hA1, 8'h00, 8'h00, 8'h90, 8'h07, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd5, 1'b0},
    // window left edge on the last column
    {8'hA1, 8'h00, 8'h00, 8'h00, 8'hA6, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd20, 8'd159, 1'b0},
    {8'hA1, 8'h00, 8'h00, 8'h00, 8'hA6, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd20, 8'd158, 1'b0},
    // window left edge past the screen
    {8'hA1, 8'h00, 8'h00, 8'h00, 8'hA7, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd20, 8'd159, 1'b0},
    {8'hA1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd20, 8'd159, 1'b0},
    // row above the window top
    {8'hA1, 8'h00, 8'h00, 8'h64, 8'h14, 8'hE4, MODE_MONO,
     CMD_RENDER, 14'h0000, 8'h00, 8'd99, 8'd50, 1'b0},
    // full color draws without the tile layer bit
    {8'h80, 8'h33, 8'hC5, 8'h00, 8'h00, 8'hE4, MODE_FULL,
     CMD_RENDER, 14'h0000, 8'h00, 8'd10, 8'd10, 1'b0},
    {8'h80, 8'h33, 8'hC5, 8'h00, 8'h00, 8'hE4, MODE_FULL_ALT,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd0, 1'b0},
    // full color window
    {8'hF8, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4, MODE_FULL,
     CMD_RENDER, 14'h0000, 8'h00, 8'd143, 8'd159, 1'b0},
    // last video and palette bytes, then a render
    {8'hF8, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4, MODE_FULL,
     CMD_WR_VRAM, 14'h3FFF, 8'h00, 8'd0, 8'd0, 1'b0},
    {8'hF8, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4, MODE_FULL,
     CMD_WR_PALETTE, 14'h003F, 8'h80, 8'd0, 8'd0, 1'b0},
    {8'hF8, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4, MODE_FULL,
     CMD_RENDER, 14'h0000, 8'h00, 8'd0, 8'd0, 1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = REG_LCD_CONTROL;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // address[13:0], data[7:0], row[7:0], column[7:0]
  logic [1:0]  s_axis_tuser  = CMD_NONE;  // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // drawn, color_index[1:0], bg_priority, rgb[23:0]

  tile_background_window_pixel_core #(
    .SCREEN_WIDTH(SCREEN_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block: memories and registers
  logic [7:0] vram_shadow [VRAM_BYTES];
  logic [7:0] pal_shadow [PAL_BYTES];
  logic [7:0] lcd_control_r = 8'h00;
  logic [7:0] scroll_y_r    = 8'h00;
  logic [7:0] scroll_x_r    = 8'h00;
  logic [7:0] window_y_r    = 8'h00;
  logic [7:0] window_x_r    = 8'h00;
  logic [7:0] shade_map_r   = SHADE_MAP_RESET;
  logic [1:0] color_mode_r  = MODE_MONO;

  result_t     pixel_q [$];
  int unsigned n_errors     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;

  // 15-bit color to 24-bit, each channel c*255/31 truncated
  function automatic logic [23:0] rgb15_to_24(input logic [14:0] c);
    int unsigned r, g, b;
    r = int'(c[4:0]) * 255 / 31;
    g = int'(c[9:5]) * 255 / 31;
    b = int'(c[14:10]) * 255 / 31;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] palette_rgb(input logic [4:0] entry);
    return rgb15_to_24({pal_shadow[{entry, 1'b1}][6:0], pal_shadow[{entry, 1'b0}]});
  endfunction

  // Map lookup, tile fetch and bit pick for one layer
  function automatic logic [1:0] tile_color_index(input logic [12:0] map_base,
                                                  input logic [7:0] line,
                                                  input logic [7:0] px,
                                                  input logic full,
                                                  input logic vflip_ok,
                                                  output logic [7:0] attr);
    logic [12:0] map_addr, tile_base;
    logic [13:0] byte_addr;
    logic [7:0]  tile_num, lo, hi;
    logic [2:0]  tile_line, bit_pos;
    map_addr  = map_base + {3'b000, line[7:3], px[7:3]};
    tile_num  = vram_shadow[{1'b0, map_addr}];
    attr      = full ? vram_shadow[{1'b1, map_addr}] : 8'h00;
    tile_base = lcd_control_r[4] ? {1'b0, tile_num, 4'b0000}
                                 : SET1_BASE + {1'b0, tile_num ^ 8'h80, 4'b0000};
    tile_line = line[2:0];
    if (vflip_ok && attr[6]) tile_line = 3'd7 - tile_line;
    byte_addr = {attr[3], tile_base + {9'd0, tile_line, 1'b0}};
    lo        = vram_shadow[byte_addr];
    hi        = vram_shadow[byte_addr | 14'd1];
    bit_pos   = attr[5] ? px[2:0] : 3'd7 - px[2:0];
    return {hi[bit_pos], lo[bit_pos]};
  endfunction

  function automatic result_t predict_render(input logic [7:0] row, input logic [7:0] col);
    result_t     res;
    logic        full, in_window;
    logic [7:0]  left, line, px, attr;
    logic [1:0]  cid, shade;
    logic [14:0] grey;
    res  = '0;
    full = (color_mode_r >= MODE_FULL);
    if (!lcd_control_r[7] || !(lcd_control_r[0] || full)) return res;
    if (row > LAST_ROW || col >= SCREEN_W) return res;
    // window covers from its top-left corner onward
    left      = (window_x_r < WX_OFFSET) ? 8'd0 : window_x_r - WX_OFFSET;
    in_window = lcd_control_r[5] && window_y_r <= row && window_y_r <= LAST_ROW &&
                left <= LAST_COLUMN && col >= left;
    if (in_window) begin
      line = row - window_y_r;
      px   = col - left;
      cid  = tile_color_index(lcd_control_r[6] ? MAP_HIGH : MAP_LOW, line, px, full,
                              1'b0, attr);
    end else begin
      line = row + scroll_y_r;
      px   = col + scroll_x_r;
      cid  = tile_color_index(lcd_control_r[3] ? MAP_HIGH : MAP_LOW, line, px, full,
                              1'b1, attr);
    end
    res.drawn       = 1'b1;
    res.color_index = cid;
    if (full) begin
      res.bg_priority = attr[7];
      res.rgb         = palette_rgb({attr[2:0], cid});
    end else begin
      shade = shade_map_r[{cid, 1'b0} +: 2];
      case (shade)
        2'd0:    grey = 15'h7FFF;
        2'd1:    grey = 15'h56B5;
        2'd2:    grey = 15'h294A;
        default: grey = 15'h0000;
      endcase
      res.rgb = (color_mode_r == MODE_COMPAT) ? palette_rgb({3'b000, shade})
                                              : rgb15_to_24(grey);
    end
    return res;
  endfunction

  // Sender gap: mostly none, some short, a few long, with gap-free bursts
  function automatic int unsigned sender_gap();
    int unsigned p;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(49) == 0) burst_left = 40;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drive one item, wait for acceptance, then update the shadow
  task automatic send_item(input cmd_e kind, input logic [13:0] addr, input logic [7:0] data,
                           input logic [7:0] row, input logic [7:0] col, input logic blank);
    int unsigned gap;
    result_t     want;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, col, row, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      CMD_WR_VRAM:    vram_shadow[addr] = data;
      CMD_WR_PALETTE: if (addr < PAL_BYTES) pal_shadow[addr[5:0]] = data;
      CMD_RENDER: begin
        if (blank) want = '0;
        else want = predict_render(row, col);
        pixel_q.push_back(want);
      end
      default: ;
    endcase
  endtask

  // Wait until all pixels are back and trailing writes have retired
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] lcdc, input logic [7:0] scy,
                              input logic [7:0] scx, input logic [7:0] wy,
                              input logic [7:0] wx, input logic [7:0] shade,
                              input logic [1:0] mode);
    settle();
    write_reg(REG_LCD_CONTROL, lcdc);
    write_reg(REG_SCROLL_Y, scy);
    write_reg(REG_SCROLL_X, scx);
    write_reg(REG_WINDOW_Y, wy);
    write_reg(REG_WINDOW_X, wx);
    write_reg(REG_SHADE_MAP, shade);
    write_reg(REG_COLOR_MODE, {6'd0, mode});
    cfg_we_i      <= 1'b0;
    lcd_control_r = lcdc;
    scroll_y_r    = scy;
    scroll_x_r    = scx;
    window_y_r    = wy;
    window_x_r    = wx;
    shade_map_r   = shade;
    color_mode_r  = mode;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel result %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.drawn !== want.drawn) begin
          $error("drawn: expected %0d, got %0d", want.drawn, got.drawn);
          n_errors++;
        end
        if (got.color_index !== want.color_index) begin
          $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
          n_errors++;
        end
        if (got.bg_priority !== want.bg_priority) begin
          $error("bg_priority: expected %0d, got %0d", want.bg_priority, got.bg_priority);
          n_errors++;
        end
        if (got.rgb !== want.rgb) begin
          $error("rgb: expected %06h, got %06h", want.rgb, got.rgb);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: ready runs with stalls, mostly short, a few long
  initial begin
    int unsigned run, hold, p;
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(20, 1);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      p = $urandom_range(99);
      if (p < 60) hold = $urandom_range(2, 1);
      else if (p < 95) hold = $urandom_range(8, 3);
      else hold = $urandom_range(60, 20);
      m_axis_tready <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
  end

  // Stimulus
  initial begin
    probe_t      pr;
    int unsigned counted, pick;
    logic [7:0]  n_lcdc, n_scy, n_scx, n_wy, n_wx, n_shade;
    logic [1:0]  n_mode;
    logic [13:0] r_addr;
    logic [7:0]  r_data, r_row, r_col;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; memories are filled once the blank rows are done
    for (int i = 0; i < N_PROBES; i++) begin
      if (i == N_BLANK_PROBES) begin
        for (int a = 0; a < VRAM_BYTES; a++)
          send_item(CMD_WR_VRAM, a[13:0], 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        for (int a = 0; a < PAL_BYTES; a++)
          send_item(CMD_WR_PALETTE, a[13:0], 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b0);
      end
      pr = probes[i];
      if (pr.lcdc != lcd_control_r || pr.scy != scroll_y_r || pr.scx != scroll_x_r ||
          pr.wy != window_y_r || pr.wx != window_x_r || pr.shade != shade_map_r ||
          pr.mode != color_mode_r)
        program_regs(pr.lcdc, pr.scy, pr.scx, pr.wy, pr.wx, pr.shade, pr.mode);
      send_item(pr.kind, pr.addr, pr.data, pr.row, pr.col, pr.blank);
    end

    // random phases, each under its own register settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) begin
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, MODE_FULL_ALT);
      end else if (ph == 1) begin
        program_regs(8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODE_MONO);
      end else begin
        n_lcdc = 8'($urandom);
        if ($urandom_range(6) != 0) n_lcdc[7] = 1'b1;
        n_scy   = 8'($urandom);
        n_scx   = 8'($urandom);
        n_wy    = 8'(($urandom_range(5) == 0) ? $urandom_range(255) : $urandom_range(143));
        n_wx    = 8'(($urandom_range(5) == 0) ? $urandom_range(255) : $urandom_range(170));
        n_shade = 8'($urandom);
        n_mode  = 2'($urandom_range(3));
        program_regs(n_lcdc, n_scy, n_scx, n_wy, n_wx, n_shade, n_mode);
      end
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick   = $urandom_range(99);
        r_addr = 14'($urandom);
        r_data = 8'($urandom);
        r_row  = 8'($urandom);
        r_col  = 8'($urandom);
        if (pick < 60) begin
          // mostly on-screen pixels
          if ($urandom_range(9) != 0) begin
            r_row = 8'($urandom_range(143));
            r_col = 8'($urandom_range(159));
          end
          send_item(CMD_RENDER, r_addr, r_data, r_row, r_col, 1'b0);
          counted++;
        end else if (pick < 85) begin
          send_item(CMD_WR_VRAM, r_addr, r_data, r_row, r_col, 1'b0);
          counted++;
        end else if (pick < 95) begin
          if ($urandom_range(4) != 0) r_addr = 14'($urandom_range(PAL_BYTES - 1));
          send_item(CMD_WR_PALETTE, r_addr, r_data, r_row, r_col, 1'b0);
          if (r_addr < PAL_BYTES) counted++;
        end else begin
          send_item(CMD_NONE, r_addr, r_data, r_row, r_col, 1'b0);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pixel_q.size() != 0) begin
      $error("%0d pixel results never arrived", pixel_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
